// ===== hdl/delta_timer_queue_with_clock_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the delta timer queue
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_WITH_CLOCK_CORE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_WITH_CLOCK_CORE_ASSERT_SVH

// Same-cycle implication
`define DTQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants, codes and types of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   // Parameter defaults
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_DELAY_BITS  = 16;

   // Field widths
   localparam int OPCODE_BITS      = 2;
   localparam int DELAY_FIELD_BITS = 16;
   localparam int PROC_BITS        = 8;
   localparam int CODE_BITS        = 16;
   localparam int MSG_BITS         = 16;
   localparam int SEC_BITS         = 6;
   localparam int MIN_BITS         = 6;
   localparam int HOUR_BITS        = 5;
   localparam int STATUS_BITS      = 2;
   localparam int DISP_BITS        = 2;
   localparam int TPS_BITS         = 20;
   localparam int CSR_INDEX_BITS   = 1;

   // Request tdata layout
   localparam int REQ_DELAY_LSB  = 0;
   localparam int REQ_SENDER_LSB = 16;
   localparam int REQ_CODE_LSB   = 24;
   localparam int REQ_MSG_LSB    = 40;
   localparam int REQ_SEC_LSB    = 56;
   localparam int REQ_MIN_LSB    = 62;
   localparam int REQ_HOUR_LSB   = 68;
   localparam int REQ_DATA_BITS  = 80;

   // Response tdata layout; the pending count sits on top
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_REL_LSB    = 2;
   localparam int RSP_PROC_LSB   = 3;
   localparam int RSP_CODE_LSB   = 11;
   localparam int RSP_MSG_LSB    = 27;
   localparam int RSP_DISP_LSB   = 43;
   localparam int RSP_SEC_LSB    = 45;
   localparam int RSP_MIN_LSB    = 51;
   localparam int RSP_HOUR_LSB   = 57;
   localparam int RSP_COUNT_LSB  = 62;

   // Operation codes
   localparam logic [OPCODE_BITS-1:0] OPC_TICK      = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OPC_REQUEST   = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OPC_SET_CLOCK = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

   // Display update codes
   localparam logic [DISP_BITS-1:0] DISP_NONE  = 2'd0;
   localparam logic [DISP_BITS-1:0] DISP_TIME  = 2'd1;
   localparam logic [DISP_BITS-1:0] DISP_BLANK = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_RATE       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_ENABLED = 1'd1;
   localparam logic [TPS_BITS-1:0]       TPS_RESET           = 20'd10;

   // Clock rollover points
   localparam logic [SEC_BITS-1:0]  SEC_LAST  = 6'd59;
   localparam logic [MIN_BITS-1:0]  MIN_LAST  = 6'd59;
   localparam logic [HOUR_BITS-1:0] HOUR_LAST = 5'd23;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FOLD,
      ST_WALK,
      ST_TICK,
      ST_TICK_CHECK,
      ST_RESULT
   } state_type;

   // Control from the sequencer to the time-of-day clock
   typedef struct packed {
      logic                 tick;
      logic                 load;
      logic [SEC_BITS-1:0]  sec;
      logic [MIN_BITS-1:0]  min;
      logic [HOUR_BITS-1:0] hour;
   } clk_ctrl_type;

   // Time and rollover flag back from the clock
   typedef struct packed {
      logic                 rolled;
      logic [SEC_BITS-1:0]  sec;
      logic [MIN_BITS-1:0]  min;
      logic [HOUR_BITS-1:0] hour;
   } clk_status_type;

endpackage

// ===== hdl/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dtq_clock.sv =====
// ----------------------------------------------------------------------------
// dtq_clock
// Time-of-day clock: sub-second tick counter, seconds, minutes, hours.
// ----------------------------------------------------------------------------
module dtq_clock
   import dtq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [TPS_BITS-1:0] tick_rate,
   input  clk_ctrl_type        clk_ctrl,
   output clk_status_type      clk_status
);

   logic [TPS_BITS-1:0]  subsec_ff, subsec_in;
   logic [SEC_BITS-1:0]  sec_ff, sec_in;
   logic [MIN_BITS-1:0]  min_ff, min_in;
   logic [HOUR_BITS-1:0] hour_ff, hour_in;
   logic [TPS_BITS:0]    subsec_next;
   logic                 rolled;

   // Flag the tick that completes a second
   assign subsec_next = {1'b0, subsec_ff} + 1'b1;
   assign rolled      = subsec_next >= {1'b0, tick_rate};

   // Count ticks, roll the time, or load it
   always_comb begin
      subsec_in = subsec_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      if (clk_ctrl.load) begin
         sec_in  = clk_ctrl.sec;
         min_in  = clk_ctrl.min;
         hour_in = clk_ctrl.hour;
      end else if (clk_ctrl.tick) begin
         if (!rolled) begin
            subsec_in = subsec_next[TPS_BITS-1:0];
         end else begin
            subsec_in = '0;
            if (sec_ff < SEC_LAST) begin
               sec_in = sec_ff + 1'b1;
            end else if (min_ff < MIN_LAST) begin
               sec_in = '0;
               min_in = min_ff + 1'b1;
            end else if (hour_ff < HOUR_LAST) begin
               sec_in  = '0;
               min_in  = '0;
               hour_in = hour_ff + 1'b1;
            end else begin
               sec_in  = '0;
               min_in  = '0;
               hour_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subsec_ff <= '0;
         sec_ff    <= '0;
         min_ff    <= '0;
         hour_ff   <= '0;
      end else begin
         subsec_ff <= subsec_in;
         sec_ff    <= sec_in;
         min_ff    <= min_in;
         hour_ff   <= hour_in;
      end
   end

   assign clk_status.rolled = rolled;
   assign clk_status.sec    = sec_ff;
   assign clk_status.min    = min_ff;
   assign clk_status.hour   = hour_ff;

endmodule

// ===== hdl/delta_timer_queue_with_clock_core.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_with_clock_core
// Delta-list timer queue with a time-of-day clock, one result per item.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives one response transfer. A set
// clock or a rejected item goes from decode to the response register, a tick
// passes through the tick and tick-check steps, and an accepted delay request
// folds the elapsed ticks into the head and then inserts in sorted order: the
// insert walks the queue memory one entry per cycle, reading the next entry
// on the read port while the write port stores the current one. The next item
// can be taken in the cycle after the response register loads. A response that
// is not taken holds the following item in its last step until the register
// frees. The queue is a ring in memory, so releasing the head is a pointer
// step; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module delta_timer_queue_with_clock_core
   import dtq_pkg::*;
#(
   parameter  int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter  int DELAY_BITS  = DEF_DELAY_BITS,
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_BITS    = ((RSP_COUNT_LSB + COUNT_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // delay, sender, wake_code, message_handle, set_sec, set_min, set_hour
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // opcode
   input  logic [OPCODE_BITS-1:0]    req_tuser,
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status, released, release_process, release_code, release_message,
   // display_update, cur_sec, cur_min, cur_hour, pending_count
   output logic [RSP_BITS-1:0]       rsp_tdata,
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TPS_BITS-1:0]       csr_data
);

   localparam int AW        = $clog2(QUEUE_DEPTH);
   localparam int WIDE_BITS = (DELAY_BITS > DELAY_FIELD_BITS) ? DELAY_BITS : DELAY_FIELD_BITS;
   localparam logic [DELAY_BITS-1:0] DELAY_MAX  = '1;
   localparam logic [AW-1:0]         LAST_SLOT  = AW'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

   typedef struct packed {
      logic [DELAY_BITS-1:0] delta;
      logic [PROC_BITS-1:0]  proc;
      logic [CODE_BITS-1:0]  code;
      logic [MSG_BITS-1:0]   msg;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Step a ring slot
   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // Control state
   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [DELAY_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TPS_BITS-1:0]   tps_ff, tps_in;
   logic                  disp_en_ff, disp_en_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item and result payload
   logic [OPCODE_BITS-1:0] op_ff, op_in;
   logic [DELAY_FIELD_BITS-1:0] delay_ff, delay_in;
   logic [PROC_BITS-1:0]   sender_ff, sender_in;
   logic [CODE_BITS-1:0]   code_ff, code_in;
   logic [MSG_BITS-1:0]    msg_ff, msg_in;
   logic [SEC_BITS-1:0]    set_sec_ff, set_sec_in;
   logic [MIN_BITS-1:0]    set_min_ff, set_min_in;
   logic [HOUR_BITS-1:0]   set_hour_ff, set_hour_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   rel_ff, rel_in;
   logic [PROC_BITS-1:0]   rel_proc_ff, rel_proc_in;
   logic [CODE_BITS-1:0]   rel_code_ff, rel_code_in;
   logic [MSG_BITS-1:0]    rel_msg_ff, rel_msg_in;
   logic [DISP_BITS-1:0]   disp_ff, disp_in;
   logic [RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;

   // Insert walk
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [DELAY_BITS-1:0] rem_ff, rem_in;
   logic                  found_ff, found_in;
   entry_type             cur_ff, cur_in;

   // Queue memory
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data, ram_rd_data;
   entry_type             ram_rd, walk_entry, new_entry;

   // Shared subtract and compare unit
   logic [DELAY_BITS-1:0] sub_x, sub_y;
   logic [DELAY_BITS:0]   sub_diff;
   logic                  sub_borrow;

   // Clock interface and item checks
   clk_ctrl_type          clk_ctrl;
   clk_status_type        clk_status;
   logic [WIDE_BITS-1:0]  delay_wide;
   logic [DELAY_BITS-1:0] delay_sat;
   logic                  req_bad, queue_full, walk_last;

   dtq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dtq_clock u_clock (
      .clock      (clock),
      .reset      (reset),
      .tick_rate  (tps_ff),
      .clk_ctrl   (clk_ctrl),
      .clk_status (clk_status)
   );

   assign ram_rd     = ram_rd_data;
   assign walk_entry = (idx_ff == '0) ? cur_ff : ram_rd;
   assign new_entry  = '{delta: rem_ff, proc: sender_ff, code: code_ff, msg: msg_ff};
   assign walk_last  = (idx_ff == count_ff);
   assign req_bad    = (delay_ff == '0) || (msg_ff == '0);
   assign queue_full = (count_ff >= FULL_COUNT);

   // Saturate the requested delay to the stored range
   assign delay_wide = WIDE_BITS'(req_tdata[REQ_DELAY_LSB +: DELAY_FIELD_BITS]);
   assign delay_sat  = (delay_wide > WIDE_BITS'(DELAY_MAX)) ? DELAY_MAX
                                                            : delay_wide[DELAY_BITS-1:0];

   // Pick subtractor operands for the current step
   always_comb begin
      case (state_ff)
         ST_FOLD: begin
            sub_x = ram_rd.delta;
            sub_y = elapsed_ff;
         end
         ST_WALK: begin
            sub_x = rem_ff;
            sub_y = walk_entry.delta;
         end
         default: begin
            sub_x = elapsed_ff;
            sub_y = cur_ff.delta;
         end
      endcase
   end

   assign sub_diff   = {1'b0, sub_x} - {1'b0, sub_y};
   assign sub_borrow = sub_diff[DELAY_BITS];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (op_ff)
               OPC_TICK:    state_in = ST_TICK;
               OPC_REQUEST: state_in = (req_bad || queue_full) ? ST_RESULT : ST_FOLD;
               default:     state_in = ST_RESULT;
            endcase
         end
         ST_FOLD:       state_in = ST_WALK;
         ST_WALK: begin
            if (walk_last) state_in = ST_RESULT;
         end
         ST_TICK:       state_in = ST_TICK_CHECK;
         ST_TICK_CHECK: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      elapsed_in   = elapsed_ff;
      op_in        = op_ff;
      delay_in     = delay_ff;
      sender_in    = sender_ff;
      code_in      = code_ff;
      msg_in       = msg_ff;
      set_sec_in   = set_sec_ff;
      set_min_in   = set_min_ff;
      set_hour_in  = set_hour_ff;
      status_in    = status_ff;
      rel_in       = rel_ff;
      rel_proc_in  = rel_proc_ff;
      rel_code_in  = rel_code_ff;
      rel_msg_in   = rel_msg_ff;
      disp_in      = disp_ff;
      idx_in       = idx_ff;
      wr_ptr_in    = wr_ptr_ff;
      rem_in       = rem_ff;
      found_in     = found_ff;
      cur_in       = cur_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff;
      ram_wr_data  = cur_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;
      req_tready   = 1'b0;
      clk_ctrl.tick = 1'b0;
      clk_ctrl.load = 1'b0;
      clk_ctrl.sec  = set_sec_ff;
      clk_ctrl.min  = set_min_ff;
      clk_ctrl.hour = set_hour_ff;

      case (state_ff)
         // Take the item and clear the result
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = req_tuser;
               delay_in    = req_tdata[REQ_DELAY_LSB  +: DELAY_FIELD_BITS];
               sender_in   = req_tdata[REQ_SENDER_LSB +: PROC_BITS];
               code_in     = req_tdata[REQ_CODE_LSB   +: CODE_BITS];
               msg_in      = req_tdata[REQ_MSG_LSB    +: MSG_BITS];
               set_sec_in  = req_tdata[REQ_SEC_LSB    +: SEC_BITS];
               set_min_in  = req_tdata[REQ_MIN_LSB    +: MIN_BITS];
               set_hour_in = req_tdata[REQ_HOUR_LSB   +: HOUR_BITS];
               rem_in      = delay_sat;
               status_in   = STATUS_OK;
               rel_in      = 1'b0;
               rel_proc_in = '0;
               rel_code_in = '0;
               rel_msg_in  = '0;
               disp_in     = DISP_NONE;
            end
         end
         // Read the head and dispatch
         ST_DECODE: begin
            ram_rd_en = 1'b1;
            idx_in    = '0;
            wr_ptr_in = head_ff;
            found_in  = 1'b0;
            case (op_ff)
               OPC_TICK: ;
               OPC_REQUEST: begin
                  if (req_bad) begin
                     status_in = STATUS_BAD;
                  end else if (queue_full) begin
                     status_in = STATUS_FULL;
                  end
               end
               OPC_SET_CLOCK: begin
                  clk_ctrl.load = 1'b1;
                  disp_in = disp_en_ff ? DISP_TIME : DISP_NONE;
               end
               default: status_in = STATUS_BAD;
            endcase
         end
         // Fold the elapsed ticks into the head entry
         ST_FOLD: begin
            cur_in       = ram_rd;
            cur_in.delta = sub_borrow ? '0 : sub_diff[DELAY_BITS-1:0];
            elapsed_in   = '0;
         end
         // Walk the queue, write one slot per cycle
         ST_WALK: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_slot(wr_ptr_ff);
            ram_wr_en   = 1'b1;
            idx_in      = idx_ff + 1'b1;
            wr_ptr_in   = next_slot(wr_ptr_ff);
            if (walk_last) begin
               ram_wr_data = found_ff ? cur_ff : new_entry;
               count_in    = count_ff + 1'b1;
            end else if (found_ff) begin
               ram_wr_data = cur_ff;
               cur_in      = walk_entry;
            end else if (!sub_borrow) begin
               ram_wr_data = walk_entry;
               rem_in      = sub_diff[DELAY_BITS-1:0];
            end else begin
               ram_wr_data  = new_entry;
               found_in     = 1'b1;
               cur_in       = walk_entry;
               cur_in.delta = walk_entry.delta - rem_ff;
            end
         end
         // Advance the clock and the elapsed count, hold the head
         ST_TICK: begin
            clk_ctrl.tick = 1'b1;
            if (clk_status.rolled) begin
               disp_in = disp_en_ff ? DISP_TIME : DISP_BLANK;
            end
            if (count_ff == '0) begin
               elapsed_in = '0;
            end else if (elapsed_ff != DELAY_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            cur_in = ram_rd;
         end
         // Release a due head entry
         ST_TICK_CHECK: begin
            if ((count_ff != '0) && !sub_borrow) begin
               rel_in      = 1'b1;
               rel_proc_in = cur_ff.proc;
               rel_code_in = cur_ff.code;
               rel_msg_in  = cur_ff.msg;
               head_in     = next_slot(head_ff);
               count_in    = count_ff - 1'b1;
               elapsed_in  = '0;
            end
         end
         // Load the response register once it is free
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_STATUS_LSB +: STATUS_BITS] = status_ff;
               rsp_data_in[RSP_REL_LSB]                   = rel_ff;
               rsp_data_in[RSP_PROC_LSB   +: PROC_BITS]   = rel_proc_ff;
               rsp_data_in[RSP_CODE_LSB   +: CODE_BITS]   = rel_code_ff;
               rsp_data_in[RSP_MSG_LSB    +: MSG_BITS]    = rel_msg_ff;
               rsp_data_in[RSP_DISP_LSB   +: DISP_BITS]   = disp_ff;
               rsp_data_in[RSP_SEC_LSB    +: SEC_BITS]    = clk_status.sec;
               rsp_data_in[RSP_MIN_LSB    +: MIN_BITS]    = clk_status.min;
               rsp_data_in[RSP_HOUR_LSB   +: HOUR_BITS]   = clk_status.hour;
               rsp_data_in[RSP_COUNT_LSB  +: COUNT_BITS]  = count_ff;
            end
         end
         default: ;
      endcase
   end

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_comb begin
      tps_in     = tps_ff;
      disp_en_in = disp_en_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TICK_RATE:       tps_in     = csr_data;
            CSR_DISPLAY_ENABLED: disp_en_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         elapsed_ff   <= '0;
         tps_ff       <= TPS_RESET;
         disp_en_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         elapsed_ff   <= elapsed_in;
         tps_ff       <= tps_in;
         disp_en_ff   <= disp_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      delay_ff    <= delay_in;
      sender_ff   <= sender_in;
      code_ff     <= code_in;
      msg_ff      <= msg_in;
      set_sec_ff  <= set_sec_in;
      set_min_ff  <= set_min_in;
      set_hour_ff <= set_hour_in;
      status_ff   <= status_in;
      rel_ff      <= rel_in;
      rel_proc_ff <= rel_proc_in;
      rel_code_ff <= rel_code_in;
      rel_msg_ff  <= rel_msg_in;
      disp_ff     <= disp_in;
      idx_ff      <= idx_in;
      wr_ptr_ff   <= wr_ptr_in;
      rem_ff      <= rem_in;
      found_ff    <= found_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/dtq_checker.sv =====
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the delta timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_timer_queue_with_clock_core_assert.svh"

module dtq_checker
   import dtq_pkg::*;
#(
   parameter  int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_BITS    = ((RSP_COUNT_LSB + COUNT_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_released;
   logic [MSG_BITS-1:0]    rsp_message;
   logic [COUNT_BITS-1:0]  rsp_pending;

   assign rsp_status   = rsp_tdata[RSP_STATUS_LSB +: STATUS_BITS];
   assign rsp_released = rsp_tdata[RSP_REL_LSB];
   assign rsp_message  = rsp_tdata[RSP_MSG_LSB +: MSG_BITS];
   assign rsp_pending  = rsp_tdata[RSP_COUNT_LSB +: COUNT_BITS];

   // A stalled response holds
   `DTQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // One item at a time: no request transfer right after another
   `DTQ_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // A release carries a real message and an ok status
   `DTQ_ASSERT_IMPL(a_release_ok, rsp_tvalid && rsp_released, (rsp_status == STATUS_OK) && (rsp_message != '0), "bad release result")

   // The pending count never passes the queue depth
   `DTQ_ASSERT_IMPL(a_count_range, rsp_tvalid, rsp_pending <= COUNT_BITS'(QUEUE_DEPTH), "pending count above depth")

endmodule

bind delta_timer_queue_with_clock_core dtq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dtq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta timer queue with time-of-day clock.
// A scoreboard keeps its own copy of the queue, the clock and the registers,
// predicts one response per accepted item and checks every response field.
// Directed items cover clock rollover, rejects and equal expiry, then random
// phases run under several register settings with random stalls on both
// channels, a long receiver hold-off and a full drain in the middle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtq_pkg::*;

   localparam int QDEPTH         = DEF_QUEUE_DEPTH;
   localparam int COUNT_W        = $clog2(QDEPTH + 1);
   localparam int RSP_W          = ((RSP_COUNT_LSB + COUNT_W + 7) / 8) * 8;
   localparam int DELAY_LIMIT    = (1 << DEF_DELAY_BITS) - 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = QDEPTH + 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 195;

   localparam logic [OPCODE_BITS-1:0] OPC_UNUSED = 2'd3;

   // One response, unpacked into its fields
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   released;
      logic [PROC_BITS-1:0]   rel_proc;
      logic [CODE_BITS-1:0]   rel_code;
      logic [MSG_BITS-1:0]    rel_msg;
      logic [DISP_BITS-1:0]   disp;
      logic [SEC_BITS-1:0]    sec;
      logic [MIN_BITS-1:0]    minute;
      logic [HOUR_BITS-1:0]   hour;
      logic [COUNT_W-1:0]     pending;
   } timer_result_type;

   // Timer queue and clock predictor with its store of expected responses
   class timer_scoreboard;
      logic [DELAY_FIELD_BITS-1:0] slot_delta [QDEPTH];
      logic [PROC_BITS-1:0]        slot_proc  [QDEPTH];
      logic [CODE_BITS-1:0]        slot_code  [QDEPTH];
      logic [MSG_BITS-1:0]         slot_msg   [QDEPTH];
      int unsigned                 slots_used;
      int unsigned                 elapsed;
      int unsigned                 subsec;
      int unsigned                 tick_rate;
      bit                          show_time;
      logic [SEC_BITS-1:0]         t_sec;
      logic [MIN_BITS-1:0]         t_min;
      logic [HOUR_BITS-1:0]        t_hour;
      timer_result_type            expected_rsp [$];
      int unsigned                 errors;
      int unsigned                 checked;
      int unsigned                 releases;
      int unsigned                 full_rejects;
      int unsigned                 bad_rejects;

      function new();
         slots_used   = 0;
         elapsed      = 0;
         subsec       = 0;
         tick_rate    = TPS_RESET;
         show_time    = 1'b1;
         t_sec        = '0;
         t_min        = '0;
         t_hour       = '0;
         errors       = 0;
         checked      = 0;
         releases     = 0;
         full_rejects = 0;
         bad_rejects  = 0;
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      // Apply one accepted item to the model state and queue its response
      function void note_request(logic [OPCODE_BITS-1:0] opc,
                                 logic [REQ_DATA_BITS-1:0] data);
         timer_result_type            r;
         logic [DELAY_FIELD_BITS-1:0] delay;
         logic [MSG_BITS-1:0]         handle;
         int unsigned                 remaining;
         int unsigned                 pos;
         int unsigned                 k;
         r      = '0;
         delay  = data[REQ_DELAY_LSB +: DELAY_FIELD_BITS];
         handle = data[REQ_MSG_LSB +: MSG_BITS];
         case (opc)
            OPC_TICK: begin
               // sub-second count and clock rollover
               if (subsec + 1 >= tick_rate) begin
                  subsec = 0;
                  if (t_sec < SEC_LAST) begin
                     t_sec++;
                  end else if (t_min < MIN_LAST) begin
                     t_sec = '0;
                     t_min++;
                  end else if (t_hour < HOUR_LAST) begin
                     t_sec = '0;
                     t_min = '0;
                     t_hour++;
                  end else begin
                     t_sec  = '0;
                     t_min  = '0;
                     t_hour = '0;
                  end
                  r.disp = show_time ? DISP_TIME : DISP_BLANK;
               end else begin
                  subsec++;
               end
               // elapsed ticks stay at zero on an empty queue, else saturate
               if (slots_used == 0)
                  elapsed = 0;
               else if (elapsed < DELAY_LIMIT)
                  elapsed++;
               // release the head once it is due
               if (slots_used > 0 && elapsed >= slot_delta[0]) begin
                  r.released = 1'b1;
                  r.rel_proc = slot_proc[0];
                  r.rel_code = slot_code[0];
                  r.rel_msg  = slot_msg[0];
                  for (k = 1; k < slots_used; k++) begin
                     slot_delta[k-1] = slot_delta[k];
                     slot_proc[k-1]  = slot_proc[k];
                     slot_code[k-1]  = slot_code[k];
                     slot_msg[k-1]   = slot_msg[k];
                  end
                  slots_used--;
                  elapsed = 0;
                  releases++;
               end
            end
            OPC_REQUEST: begin
               if (delay == 0 || handle == 0) begin
                  r.status = STATUS_BAD;
                  bad_rejects++;
               end else if (slots_used >= QDEPTH) begin
                  r.status = STATUS_FULL;
                  full_rejects++;
               end else begin
                  // fold the elapsed ticks into the head entry
                  if (slots_used > 0)
                     slot_delta[0] = (slot_delta[0] > elapsed) ?
                                     DELAY_FIELD_BITS'(slot_delta[0] - elapsed) : '0;
                  elapsed = 0;
                  // walk past every entry that expires no later than this one
                  remaining = delay;
                  pos       = 0;
                  while (pos < slots_used && slot_delta[pos] <= remaining) begin
                     remaining -= slot_delta[pos];
                     pos++;
                  end
                  if (pos < slots_used)
                     slot_delta[pos] = DELAY_FIELD_BITS'(slot_delta[pos] - remaining);
                  for (k = slots_used; k > pos; k--) begin
                     slot_delta[k] = slot_delta[k-1];
                     slot_proc[k]  = slot_proc[k-1];
                     slot_code[k]  = slot_code[k-1];
                     slot_msg[k]   = slot_msg[k-1];
                  end
                  slot_delta[pos] = DELAY_FIELD_BITS'(remaining);
                  slot_proc[pos]  = data[REQ_SENDER_LSB +: PROC_BITS];
                  slot_code[pos]  = data[REQ_CODE_LSB +: CODE_BITS];
                  slot_msg[pos]   = handle;
                  slots_used++;
                  r.status = STATUS_OK;
               end
            end
            OPC_SET_CLOCK: begin
               t_sec  = data[REQ_SEC_LSB +: SEC_BITS];
               t_min  = data[REQ_MIN_LSB +: MIN_BITS];
               t_hour = data[REQ_HOUR_LSB +: HOUR_BITS];
               r.disp = show_time ? DISP_TIME : DISP_NONE;
            end
            default: begin
               r.status = STATUS_BAD;
               bad_rejects++;
            end
         endcase
         r.sec     = t_sec;
         r.minute  = t_min;
         r.hour    = t_hour;
         r.pending = COUNT_W'(slots_used);
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string what, longint unsigned want,
                                  longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         end
      endfunction

      // Check one response transfer against the oldest expectation
      function void check_response(logic [RSP_W-1:0] tdata);
         timer_result_type want;
         timer_result_type got;
         got.status   = tdata[RSP_STATUS_LSB +: STATUS_BITS];
         got.released = tdata[RSP_REL_LSB];
         got.rel_proc = tdata[RSP_PROC_LSB +: PROC_BITS];
         got.rel_code = tdata[RSP_CODE_LSB +: CODE_BITS];
         got.rel_msg  = tdata[RSP_MSG_LSB +: MSG_BITS];
         got.disp     = tdata[RSP_DISP_LSB +: DISP_BITS];
         got.sec      = tdata[RSP_SEC_LSB +: SEC_BITS];
         got.minute   = tdata[RSP_MIN_LSB +: MIN_BITS];
         got.hour     = tdata[RSP_HOUR_LSB +: HOUR_BITS];
         got.pending  = tdata[RSP_COUNT_LSB +: COUNT_W];
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected nothing actual %h",
                     $time, tdata);
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         compare_field("status", want.status, got.status);
         compare_field("released", want.released, got.released);
         compare_field("release_process", want.rel_proc, got.rel_proc);
         compare_field("release_code", want.rel_code, got.rel_code);
         compare_field("release_message", want.rel_msg, got.rel_msg);
         compare_field("display_update", want.disp, got.disp);
         compare_field("cur_sec", want.sec, got.sec);
         compare_field("cur_min", want.minute, got.minute);
         compare_field("cur_hour", want.hour, got.hour);
         compare_field("pending_count", want.pending, got.pending);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;
   logic [OPCODE_BITS-1:0]     req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_W-1:0]           rsp_tdata;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [TPS_BITS-1:0]        csr_data;

   timer_scoreboard sb = new();
   int unsigned     items_sent;
   int unsigned     send_rush;
   int unsigned     take_rush;
   int unsigned     rsp_hold_cycles;
   int unsigned     quiet_cycles;

   delta_timer_queue_with_clock_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_fields(
      logic [DELAY_FIELD_BITS-1:0] delay, logic [PROC_BITS-1:0] sender,
      logic [CODE_BITS-1:0] code, logic [MSG_BITS-1:0] msg,
      logic [SEC_BITS-1:0] sec, logic [MIN_BITS-1:0] minute, logic [HOUR_BITS-1:0] hour);
      logic [REQ_DATA_BITS-1:0] data;
      data = '0;
      data[REQ_DELAY_LSB +: DELAY_FIELD_BITS] = delay;
      data[REQ_SENDER_LSB +: PROC_BITS]       = sender;
      data[REQ_CODE_LSB +: CODE_BITS]         = code;
      data[REQ_MSG_LSB +: MSG_BITS]           = msg;
      data[REQ_SEC_LSB +: SEC_BITS]           = sec;
      data[REQ_MIN_LSB +: MIN_BITS]           = minute;
      data[REQ_HOUR_LSB +: HOUR_BITS]         = hour;
      return data;
   endfunction

   // Offer one item after a random gap and note it once transferred
   task automatic send_item(input logic [OPCODE_BITS-1:0] opc,
                            input logic [REQ_DATA_BITS-1:0] data);
      int unsigned gap;
      if (send_rush > 0) begin
         gap = 0;
         send_rush--;
      end else begin
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 15) == 0)
            send_rush = $urandom_range(15, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opc;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(opc, data);
      items_sent++;
   endtask

   // Drop valid, wait for every response, then let the block go quiet
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [TPS_BITS-1:0] rate, input logic show);
      csr_valid <= 1'b1;
      csr_index <= CSR_TICK_RATE;
      csr_data  <= rate;
      do @(posedge clock); while (!csr_ready);
      sb.tick_rate = rate;
      csr_index <= CSR_DISPLAY_ENABLED;
      csr_data  <= {{(TPS_BITS-1){1'b0}}, show};
      do @(posedge clock); while (!csr_ready);
      sb.show_time = show;
      csr_valid <= 1'b0;
   endtask

   // One register setting followed by random traffic
   task automatic run_phase(input logic [TPS_BITS-1:0] rate, input logic show,
                            input bit hold_out, input bit pause_mid);
      int unsigned              n;
      int unsigned              r;
      int unsigned              burst_left;
      int unsigned              drain_left;
      logic [OPCODE_BITS-1:0]   opc;
      logic [REQ_DATA_BITS-1:0] data;
      settle_idle();
      write_regs(rate, show);
      burst_left = 0;
      drain_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (hold_out && n == PHASE_ITEMS / 3)
            rsp_hold_cycles = HOLD_CYCLES;
         if (pause_mid && n == PHASE_ITEMS / 2)
            settle_idle();
         // random junk in every field, then shape it per operation
         data[31:0]  = $urandom;
         data[63:32] = $urandom;
         data[79:64] = 16'($urandom);
         if (burst_left > 0) begin
            opc = OPC_REQUEST;
            burst_left--;
         end else if (drain_left > 0) begin
            opc = OPC_TICK;
            drain_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
               burst_left = $urandom_range(12, 20);
            else if (r < 5)
               drain_left = $urandom_range(20, 40);
            opc = (r < 45) ? OPC_TICK : (r < 85) ? OPC_REQUEST :
                  (r < 95) ? OPC_SET_CLOCK : OPC_UNUSED;
         end
         if (opc == OPC_REQUEST) begin
            // mostly short delays so entries expire; a few span the full range
            r = $urandom_range(0, 99);
            if (r < 5)
               data[REQ_DELAY_LSB +: DELAY_FIELD_BITS] = '0;
            else if (r < 78)
               data[REQ_DELAY_LSB +: DELAY_FIELD_BITS] = 16'($urandom_range(1, 30));
            else if (r < 99)
               data[REQ_DELAY_LSB +: DELAY_FIELD_BITS] = 16'($urandom_range(31, 200));
            if ($urandom_range(0, 19) == 0)
               data[REQ_MSG_LSB +: MSG_BITS] = '0;
            else if (data[REQ_MSG_LSB +: MSG_BITS] == 0)
               data[REQ_MSG_LSB +: MSG_BITS] = 16'd1;
         end else if (opc == OPC_SET_CLOCK && $urandom_range(0, 9) != 0) begin
            data[REQ_SEC_LSB +: SEC_BITS]   = 6'($urandom_range(0, 59));
            data[REQ_MIN_LSB +: MIN_BITS]   = 6'($urandom_range(0, 59));
            data[REQ_HOUR_LSB +: HOUR_BITS] = 5'($urandom_range(0, 23));
         end
         send_item(opc, data);
      end
   endtask

   // Response side: random stalls, rush stretches and the long hold-off
   initial begin : take_results
      int unsigned stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (take_rush > 0) begin
            stall = 0;
            take_rush--;
         end else begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
               take_rush = $urandom_range(15, 40);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
      end
   end

   initial begin : stimulus
      items_sent      = 0;
      send_rush       = 0;
      take_rush       = 0;
      rsp_hold_cycles = 0;
      quiet_cycles    = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OPC_TICK;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TICK_RATE;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values: ten ticks per second, so no update yet
      repeat (3) send_item(OPC_TICK, '0);
      settle_idle();
      write_regs(20'd1, 1'b1);

      // end of day wraps to midnight
      send_item(OPC_SET_CLOCK, pack_fields('0, '0, '0, '0, SEC_LAST, MIN_LAST, HOUR_LAST));
      send_item(OPC_TICK, '1);
      // out-of-range load takes the rollover path
      send_item(OPC_SET_CLOCK, pack_fields('0, '0, '0, '0, '1, '1, '1));
      send_item(OPC_TICK, '0);
      // seconds roll into minutes, then minutes into hours
      send_item(OPC_SET_CLOCK, pack_fields('0, '0, '0, '0, SEC_LAST, 6'd10, 5'd5));
      send_item(OPC_TICK, '0);
      send_item(OPC_SET_CLOCK, pack_fields('0, '0, '0, '0, SEC_LAST, MIN_LAST, 5'd22));
      send_item(OPC_TICK, '0);
      // rejects: zero delay, null handle, unused opcode
      send_item(OPC_REQUEST, pack_fields('0, 8'd1, 16'd1, 16'd5, '0, '0, '0));
      send_item(OPC_REQUEST, pack_fields(16'd9, 8'd2, 16'd2, '0, '0, '0, '0));
      send_item(OPC_UNUSED, '1);
      // longest delay, then two entries expiring together
      send_item(OPC_REQUEST, pack_fields('1, '1, '1, '1, '0, '0, '0));
      send_item(OPC_REQUEST, pack_fields(16'd2, 8'd0, 16'd0, 16'd1, '0, '0, '0));
      send_item(OPC_REQUEST, pack_fields(16'd2, 8'h5A, 16'h1234, 16'd2, '0, '0, '0));
      // one tick elapses, then an insert folds it into the head
      send_item(OPC_TICK, '0);
      send_item(OPC_REQUEST, pack_fields(16'd1, 8'd3, 16'd3, 16'd3, '0, '0, '0));
      repeat (3) send_item(OPC_TICK, '0);

      // random phases across the register range
      run_phase(TPS_RESET, 1'b1, 1'b0, 1'b0);
      run_phase(20'd1, 1'b0, 1'b1, 1'b0);
      run_phase(20'd0, 1'b1, 1'b0, 1'b1);
      run_phase('1, 1'b0, 1'b0, 1'b0);
      run_phase(20'd2, 1'b1, 1'b0, 1'b1);
      run_phase(20'd7, 1'b0, 1'b1, 1'b0);
      run_phase(20'd3, 1'b1, 1'b0, 1'b0);
      settle_idle();

      $display("Ran %0d items over eight register settings, %0d responses checked.",
               items_sent, sb.checked);
      $display("Saw %0d releases, %0d full-queue and %0d bad-request rejects.",
               sb.releases, sb.full_rejects, sb.bad_rejects);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
